FILE: rtl/hta_pkg.sv
// Shared types and constants for the handle table allocator.
// Used by handle_table_allocator_top; depends on nothing else.
package hta_pkg;

	// Fixed field widths of the request and result.
	localparam int ACTION_W = 2;
	localparam int DATA_W   = 32;
	localparam int HANDLE_W = 10;
	localparam int STATUS_W = 2;

	// Request operation codes.
	typedef enum logic [ACTION_W-1:0] {
		ACT_INSERT  = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_LOOKUP  = 2'd2,
		ACT_COPY    = 2'd3
	} action_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_FLAG = 2'd2
	} status_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_EVAL
	} state_t;

	// One request.
	typedef struct packed {
		action_t             action;
		logic [DATA_W-1:0]   item_value;
		logic [HANDLE_W-1:0] slot_index;
		logic [HANDLE_W-1:0] source_slot;
	} req_t;

	// One result.
	typedef struct packed {
		status_t             status;
		logic [HANDLE_W-1:0] handle_out;
		logic [DATA_W-1:0]   read_value;
	} rsp_t;

endpackage

FILE: rtl/hta_store.sv
// Entry memory of the handle table: one write port, one read port, registered read data.
// Stand-alone; no package dependency.
module hta_store #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/handle_table_allocator_top.sv
// Handle table allocator: request decode, free-slot scan and table bookkeeping.
// Depends on hta_pkg and hta_store.
//
//   Channel  Direction  Handshake               Payload
//   request  in         start high, busy low    req  (hta_pkg::req_t)
//   result   out        done, one cycle         rsp  (hta_pkg::rsp_t)
//
// Release, lookup and copy do one memory read, then the decision and, for release and copy, a write.
// Insert reads slots onward from the search pointer, stepping over occupied ones; the
// single read port of the entry memory sets one slot per cycle.
// The result is registered onto rsp in the cycle after the last cycle of its request; busy is low in that
// cycle, so the next request may be taken at once.
// After reset a clearing pass writes zero to all TABLE_DEPTH entries, one a cycle, busy high.
// The receiver cannot stall: every result is taken in the cycle that done is high.
module handle_table_allocator_top #(
	parameter int TABLE_DEPTH = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  hta_pkg::req_t req,
	output logic          done,
	output hta_pkg::rsp_t rsp
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int MW = (VALUE_WIDTH < hta_pkg::DATA_W) ? VALUE_WIDTH : hta_pkg::DATA_W;

	hta_pkg::state_t state_q, state_d;
	hta_pkg::req_t   req_q;
	hta_pkg::rsp_t   rsp_q, rsp_d;

	logic [AW-1:0]          clr_q;
	logic [AW-1:0]          ptr_q, ptr_nxt;
	logic [CW-1:0]          cnt_q;
	logic [AW-1:0]          sp_q;
	logic [CW-1:0]          fc_q;
	logic                   done_q, done_d;

	logic                   rd_en, wr_en;
	logic [AW-1:0]          rd_addr, wr_addr;
	logic [VALUE_WIDTH-1:0] rd_data, wr_data;

	logic                   accept;
	logic                   sp_ld, fc_inc, fc_dec;
	logic                   slot_ok, src_ok, in_slot_ok, in_src_ok;
	logic [AW-1:0]          slot_ix, in_slot_ix, in_src_ix;
	logic                   val_zero, rd_zero, cnt_last;
	logic [VALUE_WIDTH-1:0] ins_data;

	assign accept = start && (state_q == hta_pkg::S_IDLE);
	assign busy   = (state_q != hta_pkg::S_IDLE);

	// Handle range checks and memory indexes, for the incoming and the held request.
	assign in_slot_ok = (32'(req.slot_index) < 32'(TABLE_DEPTH));
	assign in_src_ok  = (32'(req.source_slot) < 32'(TABLE_DEPTH));
	assign in_slot_ix = in_slot_ok ? AW'(req.slot_index) : '0;
	assign in_src_ix  = in_src_ok ? AW'(req.source_slot) : '0;
	assign slot_ok    = (32'(req_q.slot_index) < 32'(TABLE_DEPTH));
	assign src_ok     = (32'(req_q.source_slot) < 32'(TABLE_DEPTH));
	assign slot_ix    = slot_ok ? AW'(req_q.slot_index) : '0;

	// Value as stored, and the tests on it and on the entry just read.
	assign val_zero = (req_q.item_value[MW-1:0] == '0);
	assign ins_data = VALUE_WIDTH'(req_q.item_value[MW-1:0]);
	assign rd_zero  = (rd_data == '0);

	// Scan position: next slot with wrap, and the test for a full sweep.
	assign ptr_nxt  = (ptr_q == AW'(TABLE_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
	assign cnt_last = (cnt_q == CW'(TABLE_DEPTH - 1));

	hta_store #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH (VALUE_WIDTH)
	) u_store (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hta_pkg::S_CLEAR: begin
				if (clr_q == AW'(TABLE_DEPTH - 1)) begin
					state_d = hta_pkg::S_IDLE;
				end
			end
			hta_pkg::S_IDLE: begin
				if (start) begin
					state_d = (req.action == hta_pkg::ACT_INSERT) ? hta_pkg::S_SCAN
					                                              : hta_pkg::S_EVAL;
				end
			end
			hta_pkg::S_SCAN: begin
				if (val_zero || (fc_q == '0) || rd_zero || cnt_last) begin
					state_d = hta_pkg::S_IDLE;
				end
			end
			hta_pkg::S_EVAL: begin
				state_d = hta_pkg::S_IDLE;
			end
			default: begin
				state_d = hta_pkg::S_CLEAR;
			end
		endcase
	end

	// Memory accesses, result and bookkeeping controls.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		done_d  = 1'b0;
		sp_ld   = 1'b0;
		fc_inc  = 1'b0;
		fc_dec  = 1'b0;
		rsp_d   = '{status: hta_pkg::ST_OK, handle_out: '0, read_value: '0};
		unique case (state_q)
			hta_pkg::S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
			end
			hta_pkg::S_IDLE: begin
				// Insert starts at the search pointer, copy reads its source.
				rd_en = start;
				case (req.action)
					hta_pkg::ACT_INSERT: rd_addr = sp_q;
					hta_pkg::ACT_COPY:   rd_addr = in_src_ix;
					default:             rd_addr = in_slot_ix;
				endcase
			end
			hta_pkg::S_SCAN: begin
				if (val_zero) begin
					done_d       = 1'b1;
					rsp_d.status = hta_pkg::ST_FLAG;
				end else if ((fc_q == '0) || (!rd_zero && cnt_last)) begin
					done_d       = 1'b1;
					rsp_d.status = hta_pkg::ST_FULL;
				end else if (rd_zero) begin
					// Free slot found: claim it and park the pointer there.
					done_d           = 1'b1;
					wr_en            = 1'b1;
					wr_addr          = ptr_q;
					wr_data          = ins_data;
					sp_ld            = 1'b1;
					fc_dec           = 1'b1;
					rsp_d.handle_out = hta_pkg::HANDLE_W'(ptr_q);
				end else begin
					rd_en   = 1'b1;
					rd_addr = ptr_nxt;
				end
			end
			hta_pkg::S_EVAL: begin
				done_d = 1'b1;
				case (req_q.action)
					hta_pkg::ACT_RELEASE: begin
						if (!slot_ok || rd_zero) begin
							rsp_d.status = hta_pkg::ST_FLAG;
						end else begin
							wr_en   = 1'b1;
							wr_addr = slot_ix;
							fc_inc  = (fc_q < CW'(TABLE_DEPTH));
						end
					end
					hta_pkg::ACT_LOOKUP: begin
						if (slot_ok) begin
							rsp_d.read_value = hta_pkg::DATA_W'(rd_data[MW-1:0]);
						end
					end
					hta_pkg::ACT_COPY: begin
						if (slot_ok && src_ok) begin
							wr_en   = 1'b1;
							wr_addr = slot_ix;
							wr_data = rd_data;
						end
					end
					default: begin
						done_d = 1'b1;
					end
				endcase
			end
			default: begin
				done_d = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hta_pkg::S_CLEAR;
			clr_q   <= '0;
			ptr_q   <= '0;
			cnt_q   <= '0;
			sp_q    <= '0;
			fc_q    <= CW'(TABLE_DEPTH);
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (state_q == hta_pkg::S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (accept) begin
				ptr_q <= sp_q;
				cnt_q <= '0;
			end else if (state_q == hta_pkg::S_SCAN) begin
				ptr_q <= ptr_nxt;
				cnt_q <= cnt_q + 1'b1;
			end
			if (sp_ld) begin
				sp_q <= ptr_q;
			end
			if (fc_inc) begin
				fc_q <= fc_q + 1'b1;
			end else if (fc_dec) begin
				fc_q <= fc_q - 1'b1;
			end
		end
	end

	// Request and result holding registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (done_d) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// Free count never exceeds the table size.
	a_fc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= CW'(TABLE_DEPTH))
		else $error("free count above table depth");

	// A result follows a cycle of work on some request.
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == hta_pkg::S_SCAN || state_q == hta_pkg::S_EVAL))
		else $error("result without a request in progress");

	// A scan never sweeps more than the whole table.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hta_pkg::S_SCAN) |-> (cnt_q < CW'(TABLE_DEPTH)))
		else $error("scan ran past the table size");

	// A granted handle is the slot where the search pointer now rests.
	a_handle_is_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.handle_out != '0)) |-> (rsp.handle_out == hta_pkg::HANDLE_W'(sp_q)))
		else $error("granted handle differs from search pointer");

endmodule
